### design/tss_pkg.sv
// tilt stick shaper package: shared types, constants and controller states
// no dependencies
package tss_pkg;

   localparam int ONE_Q14     = 16384;
   localparam int SLEW_STEP   = 1638;
   localparam int DIV_W       = 48;
   localparam int DEF_ANGLE   = 90;

   // reciprocals for exact floor division by 25 (inputs below 2^22) and 45 (below 2^20)
   localparam int RECIP_25       = 5368710;
   localparam int RECIP_25_SHIFT = 27;
   localparam int RECIP_45       = 1491309;
   localparam int RECIP_45_SHIFT = 26;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_SQRT,
      ST_SF_SET,
      ST_SF_DIV,
      ST_SK_SET,
      ST_SK_DIV,
      ST_DZ_SET,
      ST_DZ_DIV,
      ST_AMT_SET,
      ST_AMT_DIV,
      ST_CB_MUL,
      ST_CB_SET,
      ST_CB_DIV,
      ST_HALF,
      ST_TX_SET,
      ST_TX_DIV,
      ST_TY_SET,
      ST_TY_DIV,
      ST_SLEW,
      ST_OX_SET,
      ST_OX_DIV,
      ST_OY_SET,
      ST_OY_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     load;
      state_type step;
      logic     div_start;
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic div_done;
      logic zero_vec;
   } sts_type;

   typedef enum logic [1:0] {
      CSR_DEAD_ZONE = 2'd0,
      CSR_CIRCLE    = 2'd1,
      CSR_ANGLE     = 2'd2
   } csr_index_type;

endpackage

### design/tss_ctrl.sv
// tilt stick shaper controller: sequences the datapath one step at a time
// depends on tss_pkg
module tss_ctrl
   import tss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_PREP;
         ST_PREP:    state_in = sts.zero_vec ? ST_SLEW : ST_SQRT;
         ST_SQRT:    if (sts.root_done) state_in = ST_SF_SET;
         ST_SF_SET:  state_in = ST_SF_DIV;
         ST_SF_DIV:  if (sts.div_done) state_in = ST_SK_SET;
         ST_SK_SET:  state_in = ST_SK_DIV;
         ST_SK_DIV:  state_in = ST_DZ_SET;
         ST_DZ_SET:  state_in = ST_DZ_DIV;
         ST_DZ_DIV:  if (sts.div_done) state_in = ST_AMT_SET;
         ST_AMT_SET: state_in = ST_AMT_DIV;
         ST_AMT_DIV: if (sts.div_done) state_in = ST_CB_MUL;
         ST_CB_MUL:  state_in = ST_CB_SET;
         ST_CB_SET:  state_in = ST_CB_DIV;
         ST_CB_DIV:  state_in = ST_HALF;
         ST_HALF:    state_in = ST_TX_SET;
         ST_TX_SET:  state_in = ST_TX_DIV;
         ST_TX_DIV:  if (sts.div_done) state_in = ST_TY_SET;
         ST_TY_SET:  state_in = ST_TY_DIV;
         ST_TY_DIV:  if (sts.div_done) state_in = ST_SLEW;
         ST_SLEW:    state_in = ST_OX_SET;
         ST_OX_SET:  state_in = ST_OX_DIV;
         ST_OX_DIV:  state_in = ST_OY_SET;
         ST_OY_SET:  state_in = ST_OY_DIV;
         ST_OY_DIV:  state_in = ST_OUT;
         ST_OUT:     if (!rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid     = (state_ff == ST_OUT);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.step      = state_ff;
      cmd.div_start = (state_ff == ST_SF_SET) || (state_ff == ST_DZ_SET) ||
                      (state_ff == ST_AMT_SET) || (state_ff == ST_TX_SET) ||
                      (state_ff == ST_TY_SET);
   end

endmodule

### design/tss_div.sv
// tilt stick shaper restoring divider, one quotient bit per cycle
// depends on tss_pkg
module tss_div
   import tss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DIV_W:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   assign quotient = quo_ff;
   assign done     = !busy_ff && !start;

endmodule

### design/tss_dp.sv
// tilt stick shaper datapath: vector prep, root, shaping, slew and output scale
// depends on tss_pkg and tss_div
module tss_dp
   import tss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [12:0] forward_level,
   input  logic [12:0] backward_level,
   input  logic [12:0] left_level,
   input  logic [12:0] right_level,
   input  logic        half_modifier,
   input  logic        advance,
   input  logic [5:0]  dead_zone,
   input  logic [6:0]  circle,
   input  logic [7:0]  angle,
   output logic signed [15:0] tilt_x_out,
   output logic signed [15:0] tilt_y_out
);

   // vector and flags
   logic signed [15:0] x_ff, y_ff;
   logic [14:0]        ax_ff, ay_ff, m_ff;
   logic               half_ff, adv_ff;
   // root
   logic [31:0]        rv_ff, rres_ff, rbit_ff;
   // shaping values
   logic [15:0]        r_ff;
   logic [DIV_W-1:0]   sf_ff, sk_ff, dist_ff, amt_ff, prod_ff;
   logic               cneg_ff;
   logic signed [15:0] tx_ff, ty_ff, hx_ff, hy_ff, ox_ff, oy_ff;
   // constant division operand
   logic [21:0]        num_ff;
   // divider
   logic [DIV_W-1:0]   dvd, dvs, quo;
   logic               ddone;

   tss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .quotient (quo),
      .done     (ddone)
   );

   function automatic logic signed [15:0] slew(input logic signed [15:0] h,
                                               input logic signed [15:0] t);
      logic signed [16:0] n;
      begin
         n = 17'(h);
         if (t > h) begin
            n = 17'(h) + 17'(SLEW_STEP);
            slew = (n < 17'(t)) ? n[15:0] : t;
         end else if (t < h) begin
            n = 17'(h) - 17'(SLEW_STEP);
            slew = (n > 17'(t)) ? n[15:0] : t;
         end else begin
            slew = h;
         end
      end
   endfunction

   logic signed [15:0] dx, dy;
   logic [31:0]        sq;
   logic [33:0]        rsum;
   logic [DIV_W-1:0]   sfm, hundred_sf, csfm, skn, dzp, dzt;
   logic [DIV_W-1:0]   p25, q25, p45, q45;
   logic [14:0]        axis_mag;
   logic [15:0]        omag, hx_mag, hy_mag;

   assign dx = 16'(signed'({3'b0, right_level})) - 16'(signed'({3'b0, left_level}));
   assign dy = 16'(signed'({3'b0, forward_level})) - 16'(signed'({3'b0, backward_level}));
   assign sq = 32'(ax_ff) * 32'(ax_ff) + 32'(ay_ff) * 32'(ay_ff);
   assign rsum = 34'(rres_ff) + 34'(rbit_ff);
   assign sfm = (sf_ff >= DIV_W'(ONE_Q14)) ? sf_ff - DIV_W'(ONE_Q14) : '0;
   assign hundred_sf = sf_ff * DIV_W'(100);
   assign csfm = sfm * DIV_W'(circle);
   assign skn = hundred_sf - csfm;
   assign dzp = DIV_W'(r_ff) * DIV_W'(100);
   assign dzt = sk_ff * DIV_W'(dead_zone);
   assign hx_mag = hx_ff[15] ? 16'(-hx_ff) : 16'(hx_ff);
   assign hy_mag = hy_ff[15] ? 16'(-hy_ff) : 16'(hy_ff);

   // divide by 25 and by 45 through reciprocal multiplies
   assign p25 = DIV_W'(num_ff) * DIV_W'(RECIP_25);
   assign q25 = p25 >> RECIP_25_SHIFT;
   assign p45 = DIV_W'(num_ff) * DIV_W'(RECIP_45);
   assign q45 = p45 >> RECIP_45_SHIFT;

   always_comb begin
      dvd = '0;
      dvs = DIV_W'(1);
      case (cmd.step)
         ST_SF_SET:  begin dvd = DIV_W'(r_ff) << 14; dvs = DIV_W'(m_ff); end
         ST_DZ_SET:  begin
            dvd = (dzp > dzt) ? dzp - dzt : '0;
            dvs = DIV_W'(7'd100 - {1'b0, dead_zone});
         end
         ST_AMT_SET: begin dvd = dist_ff << 14; dvs = sk_ff; end
         ST_TX_SET:  begin
            dvd = DIV_W'(ax_ff) * DIV_W'(dist_ff[31:0]);
            dvs = DIV_W'(r_ff);
         end
         ST_TY_SET:  begin
            dvd = DIV_W'(ay_ff) * DIV_W'(dist_ff[31:0]);
            dvs = DIV_W'(r_ff);
         end
         default:    begin dvd = '0; dvs = DIV_W'(1); end
      endcase
   end

   always_comb begin
      axis_mag = (quo > DIV_W'(ONE_Q14)) ? 15'(ONE_Q14) : quo[14:0];
      omag     = (q45 > DIV_W'(ONE_Q14)) ? 16'(ONE_Q14) : q45[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hx_ff    <= '0;
         hy_ff    <= '0;
      end else begin
         if (cmd.step == ST_SLEW && adv_ff) begin
            hx_ff <= slew(hx_ff, tx_ff);
            hy_ff <= slew(hy_ff, ty_ff);
         end
      end
      if (cmd.load) begin
         x_ff    <= dx <<< 2;
         y_ff    <= dy <<< 2;
         ax_ff   <= 15'(dx[15] ? -dx : dx) << 2;
         ay_ff   <= 15'(dy[15] ? -dy : dy) << 2;
         half_ff <= half_modifier;
         adv_ff  <= advance;
         tx_ff   <= '0;
         ty_ff   <= '0;
      end
      case (cmd.step)
         ST_PREP: begin
            m_ff    <= (ax_ff > ay_ff) ? ax_ff : ay_ff;
            rv_ff   <= sq;
            rres_ff <= '0;
            rbit_ff <= 32'h4000_0000;
         end
         ST_SQRT: begin
            // one result bit per cycle
            if (rbit_ff != 32'd0) begin
               if (34'(rv_ff) >= rsum) begin
                  rv_ff   <= rv_ff - rsum[31:0];
                  rres_ff <= (rres_ff >> 1) + rbit_ff;
               end else begin
                  rres_ff <= rres_ff >> 1;
               end
               rbit_ff <= rbit_ff >> 2;
            end else begin
               r_ff <= rres_ff[15:0];
            end
         end
         ST_SF_DIV:  if (ddone) sf_ff <= quo;
         // divide by 100 as a shift by two and a divide by 25
         ST_SK_SET:  num_ff <= 22'(skn >> 2);
         ST_SK_DIV:  sk_ff <= (q25 == '0) ? DIV_W'(1) : q25;
         ST_DZ_DIV:  if (ddone) dist_ff <= quo;
         ST_AMT_DIV: if (ddone) amt_ff <= quo;
         ST_CB_MUL:  begin
            prod_ff <= DIV_W'(sfm[15:0]) * DIV_W'(amt_ff[31:0]);
            cneg_ff <= 1'b0;
         end
         // circle blend term: sfm * amt * c over 16384 * 100
         ST_CB_SET:  num_ff <= 22'((prod_ff * DIV_W'(circle)) >> 16);
         ST_CB_DIV:  if (!cneg_ff) dist_ff <= dist_ff + q25;
         ST_HALF:    if (half_ff) dist_ff <= dist_ff >> 1;
         ST_TX_DIV:  if (ddone) tx_ff <= x_ff[15] ? -16'(axis_mag) : 16'(axis_mag);
         ST_TY_DIV:  if (ddone) ty_ff <= y_ff[15] ? -16'(axis_mag) : 16'(axis_mag);
         // divide by 180 as a shift by two and a divide by 45
         ST_OX_SET:  num_ff <= 22'((DIV_W'(hx_mag) * DIV_W'(angle)) >> 2);
         ST_OX_DIV:  ox_ff <= hx_ff[15] ? -omag : omag;
         ST_OY_SET:  num_ff <= 22'((DIV_W'(hy_mag) * DIV_W'(angle)) >> 2);
         ST_OY_DIV:  oy_ff <= hy_ff[15] ? -omag : omag;
         default: ;
      endcase
   end

   assign sts.root_done = (cmd.step == ST_SQRT) && (rbit_ff == 32'd0);
   assign sts.div_done  = ddone;
   assign sts.zero_vec  = (ax_ff == '0) && (ay_ff == '0);
   assign tilt_x_out    = ox_ff;
   assign tilt_y_out    = oy_ff;

endmodule

### design/tilt_stick_shaper_slew_limiter_core.sv
// Tilt stick shaper with slew limiter. One item is in flight at a time; a
// shaped item runs five divisions on the shared one-bit-per-cycle divider,
// the square root and the remaining steps (the constant divisions use
// reciprocal multiplies). A centered stick skips shaping. The next item is
// accepted no earlier than the cycle after the result transfer. req_stall is
// high from acceptance until the result transfer completes.
// depends on tss_pkg, tss_ctrl, tss_dp
module tilt_stick_shaper_slew_limiter_core
   import tss_pkg::*;
#(
   parameter int DefAngle = DEF_ANGLE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [12:0]        req_forward_level,
   input  logic [12:0]        req_backward_level,
   input  logic [12:0]        req_left_level,
   input  logic [12:0]        req_right_level,
   input  logic               req_half_modifier,
   input  logic               req_advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_tilt_x_out,
   output logic signed [15:0] rsp_tilt_y_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);

   logic [5:0] dz_ff;
   logic [6:0] circ_ff;
   logic [7:0] ang_ff;
   cmd_type    cmd;
   sts_type    sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff   <= '0;
         circ_ff <= '0;
         ang_ff  <= 8'(DefAngle);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEAD_ZONE: dz_ff   <= csr_data[5:0];
            CSR_CIRCLE:    circ_ff <= csr_data[6:0];
            CSR_ANGLE:     ang_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tss_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .forward_level  (req_forward_level),
      .backward_level (req_backward_level),
      .left_level     (req_left_level),
      .right_level    (req_right_level),
      .half_modifier  (req_half_modifier),
      .advance        (req_advance),
      .dead_zone      (dz_ff),
      .circle         (circ_ff),
      .angle          (ang_ff),
      .tilt_x_out     (rsp_tilt_x_out),
      .tilt_y_out     (rsp_tilt_y_out)
   );

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result shown while accepting");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tilt_x_out))
      else $error("stalled result changed");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("accept did not start work");

endmodule
